// ===== rtl/vtyp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtyp_pkg
// shared constants and the cordic step angle table for the yaw/pitch pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package vtyp_pkg;

  localparam int NORM_W    = 48;
  localparam int NORM_TOP  = 46;
  localparam int HALF_W    = NORM_W / 2;
  localparam int SHIFT_W   = 6;
  localparam int DATA_W    = 54;
  localparam int ACC_W     = 44;
  localparam int ACC_FRAC  = 32;
  localparam int STEPS     = 40;
  localparam int TAB_LEN   = 14;
  localparam int GAIN_W    = 31;
  localparam int PP_W      = HALF_W + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_Q30     = 31'd1768195363;
  localparam longint            RAD_TO_DEG   = 64'sd246083499208;
  localparam longint            HALF_TURN    = 64'sd180 <<< ACC_FRAC;

  localparam longint ATAN_TAB [TAB_LEN] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239180,  64'sd7687607525,   64'sd3844741810,  64'sd1922488225,
    64'sd961258780,    64'sd480631223,    64'sd240315841,   64'sd120157949,
    64'sd60078978,     64'sd30039489
  };

  // atan(2^-i) in degrees with 32 fraction bits
  function automatic logic signed [ACC_W-1:0] step_angle(input int unsigned i);
    longint t;
    if (i < TAB_LEN) begin
      t = ATAN_TAB[i];
    end else begin
      t = (RAD_TO_DEG + (64'sd1 <<< (i - 1))) >>> i;
    end
    return ACC_W'(t);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vector_to_yaw_pitch_top.sv =====
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_top
// direction vector to yaw and pitch in degrees via two chained cordic passes
// ----------------------------------------------------------------------------
// Takes one signed (x, y, z) beat per cycle unless stall_o is high and returns
// yaw = atan2(y, x) and pitch = atan2(-z, horizontal length), both unsigned
// degrees in [0, 360) with ANGLE_FRAC_BITS fraction bits. The pipeline is
// built from the two 40-step cordic vectoring pipelines (one step per stage)
// plus input, magnitude, normalize, align and rounding stages. The whole
// pipeline holds while a finished beat is stalled at the output register.
`default_nettype none

module vector_to_yaw_pitch_top
  import vtyp_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   stall_o,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_z_i,
  output logic                                   valid_o,
  input  wire logic                              stall_i,
  output logic [ANGLE_FRAC_BITS+8:0]             yaw_deg_o,
  output logic [ANGLE_FRAC_BITS+8:0]             pitch_deg_o
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int OW = ANGLE_FRAC_BITS + 9;
  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] FULL_TURN =
    ACC_W'(64'sd360 <<< ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (SH - 1));
  localparam logic [OW-1:0] PITCH_UP   = OW'(64'd270 << ANGLE_FRAC_BITS);
  localparam logic [OW-1:0] PITCH_DOWN = OW'(64'd90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic               hz;
    logic               zpos;
    logic [SHIFT_W-1:0] s1;
    logic [SHIFT_W-1:0] s2;
    logic [NORM_W-1:0]  zm;
  } side1_t;

  typedef struct packed {
    logic          hz;
    logic          zpos;
    logic [OW-1:0] yaw;
  } side2_t;

  function automatic logic [NORM_W-1:0] mag(input logic signed [CW-1:0] v);
    logic [CW:0] t;
    t = v[CW-1] ? (CW+1)'(-{v[CW-1], v}) : (CW+1)'({1'b0, v});
    return NORM_W'(t);
  endfunction

  function automatic logic [SHIFT_W-1:0] nshift(input logic [NORM_W-1:0] m);
    logic [SHIFT_W-1:0] p;
    p = '0;
    for (int k = 0; k < NORM_W; k++) begin
      if (m[k]) p = SHIFT_W'(k);
    end
    return (p < SHIFT_W'(NORM_TOP)) ? SHIFT_W'(NORM_TOP) - p : '0;
  endfunction

  function automatic logic [OW-1:0] to_out(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + RND_HALF) >>> SH;
    if (r < 0) r = r + FULL_TURN;
    if (r >= FULL_TURN) r = r - FULL_TURN;
    return r[OW-1:0];
  endfunction

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // input register
  logic                 v1_q;
  logic signed [CW-1:0] x1_q, y1_q, z1_q;

  // magnitudes
  logic              v2_q;
  logic [NORM_W-1:0] mx2_q, my2_q, mz2_q;
  logic              hz2_q, xneg2_q, yneg2_q, zpos2_q, zzero2_q;

  // normalize shifts
  logic               v3_q;
  logic [NORM_W-1:0]  mx3_q, my3_q, mz3_q;
  logic               hz3_q, xneg3_q, yneg3_q, zpos3_q;
  logic [SHIFT_W-1:0] s1_3_q, s2_3_q;

  // cordic passes
  logic                     p1v_q [STEPS+1];
  logic signed [DATA_W-1:0] p1x_q [STEPS+1];
  logic signed [DATA_W-1:0] p1y_q [STEPS+1];
  logic signed [ACC_W-1:0]  p1a_q [STEPS+1];
  side1_t                   p1s_q [STEPS+1];

  logic                     p2v_q [STEPS+1];
  logic signed [DATA_W-1:0] p2x_q [STEPS+1];
  logic signed [DATA_W-1:0] p2y_q [STEPS+1];
  logic signed [ACC_W-1:0]  p2a_q [STEPS+1];
  side2_t                   p2s_q [STEPS+1];

  logic [PP_W-1:0] pp_hi_q, pp_lo_q;

  logic [OW-1:0] yaw_q, pitch_q;
  logic          out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      p1v_q[0] <= 1'b0;
      p2v_q[0] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      p1v_q[0] <= v3_q;
      p2v_q[0] <= p1v_q[STEPS];
      out_v_q <= p2v_q[STEPS];
    end
  end

  logic [NORM_W-1:0]        xs_d, ys_d;
  logic [DATA_W-1:0]        r_d;
  logic [NORM_W-1:0]        bz_d;
  logic [SHIFT_W-1:0]       dsh_d;
  logic [PP_W:0]            lo_sum_d;
  side1_t                   gain_s_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= vec_x_i;
      y1_q <= vec_y_i;
      z1_q <= vec_z_i;

      mx2_q    <= mag(x1_q);
      my2_q    <= mag(y1_q);
      mz2_q    <= mag(z1_q);
      hz2_q    <= (x1_q == '0) && (y1_q == '0);
      xneg2_q  <= x1_q[CW-1];
      yneg2_q  <= y1_q[CW-1];
      zpos2_q  <= !z1_q[CW-1] && (z1_q != '0);
      zzero2_q <= (z1_q == '0);

      mx3_q   <= mx2_q;
      my3_q   <= my2_q;
      mz3_q   <= mz2_q;
      hz3_q   <= hz2_q;
      xneg3_q <= xneg2_q;
      yneg3_q <= yneg2_q;
      zpos3_q <= zpos2_q;
      s1_3_q  <= nshift((mx2_q > my2_q) ? mx2_q : my2_q);
      s2_3_q  <= zzero2_q ? nshift((mx2_q > my2_q) ? mx2_q : my2_q) : nshift(mz2_q);

      p1x_q[0]    <= DATA_W'(xs_d);
      p1y_q[0]    <= (yneg3_q ^ xneg3_q) ? -DATA_W'(ys_d) : DATA_W'(ys_d);
      p1a_q[0]    <= xneg3_q ? ACC_W'(HALF_TURN) : '0;
      p1s_q[0].hz   <= hz3_q;
      p1s_q[0].zpos <= zpos3_q;
      p1s_q[0].s1   <= s1_3_q;
      p1s_q[0].s2   <= s2_3_q;
      p1s_q[0].zm   <= mz3_q << s2_3_q;

      pp_hi_q <= PP_W'(p1s_q[0].zm[NORM_W-1:HALF_W]) * PP_W'(GAIN_Q30);
      pp_lo_q <= PP_W'(p1s_q[0].zm[HALF_W-1:0]) * PP_W'(GAIN_Q30);

      p2x_q[0]      <= $signed(r_d);
      p2y_q[0]      <= p1s_q[STEPS].zpos ? -DATA_W'(bz_d) : DATA_W'(bz_d);
      p2a_q[0]      <= '0;
      p2s_q[0].hz   <= p1s_q[STEPS].hz;
      p2s_q[0].zpos <= p1s_q[STEPS].zpos;
      p2s_q[0].yaw  <= p1s_q[STEPS].hz ? '0 : to_out(p1a_q[STEPS]);

      yaw_q   <= p2s_q[STEPS].yaw;
      pitch_q <= p2s_q[STEPS].hz ? (p2s_q[STEPS].zpos ? PITCH_UP : PITCH_DOWN)
                                 : to_out(p2a_q[STEPS]);
    end
  end

  assign xs_d = mx3_q << s1_3_q;
  assign ys_d = my3_q << s1_3_q;

  // align horizontal length and scaled z to the smaller normalize shift
  always_comb begin
    r_d    = $unsigned(p1x_q[STEPS]);
    bz_d   = p1s_q[STEPS].zm;
    dsh_d  = '0;
    if (p1s_q[STEPS].s1 > p1s_q[STEPS].s2) begin
      dsh_d = p1s_q[STEPS].s1 - p1s_q[STEPS].s2;
      r_d   = r_d >> dsh_d;
    end else if (p1s_q[STEPS].s2 > p1s_q[STEPS].s1) begin
      dsh_d = p1s_q[STEPS].s2 - p1s_q[STEPS].s1;
      bz_d  = bz_d >> dsh_d;
    end
  end

  assign lo_sum_d = (PP_W+1)'({pp_hi_q[5:0], {HALF_W{1'b0}}}) + (PP_W+1)'(pp_lo_q);

  // gain-scaled z joins the side data two steps into the first pass
  always_comb begin
    gain_s_d    = p1s_q[1];
    gain_s_d.zm = NORM_W'(pp_hi_q >> 6) + NORM_W'(lo_sum_d >> 30);
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic signed [ACC_W-1:0] ANG = step_angle(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p1v_q[i+1] <= 1'b0;
        p2v_q[i+1] <= 1'b0;
      end else if (en) begin
        p1v_q[i+1] <= p1v_q[i];
        p2v_q[i+1] <= p2v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!p1y_q[i][DATA_W-1]) begin
          p1x_q[i+1] <= p1x_q[i] + (p1y_q[i] >>> i);
          p1y_q[i+1] <= p1y_q[i] - (p1x_q[i] >>> i);
          p1a_q[i+1] <= p1a_q[i] + ANG;
        end else begin
          p1x_q[i+1] <= p1x_q[i] - (p1y_q[i] >>> i);
          p1y_q[i+1] <= p1y_q[i] + (p1x_q[i] >>> i);
          p1a_q[i+1] <= p1a_q[i] - ANG;
        end
        p1s_q[i+1] <= (i == 1) ? gain_s_d : p1s_q[i];

        if (!p2y_q[i][DATA_W-1]) begin
          p2x_q[i+1] <= p2x_q[i] + (p2y_q[i] >>> i);
          p2y_q[i+1] <= p2y_q[i] - (p2x_q[i] >>> i);
          p2a_q[i+1] <= p2a_q[i] + ANG;
        end else begin
          p2x_q[i+1] <= p2x_q[i] - (p2y_q[i] >>> i);
          p2y_q[i+1] <= p2y_q[i] + (p2x_q[i] >>> i);
          p2a_q[i+1] <= p2a_q[i] - ANG;
        end
        p2s_q[i+1] <= p2s_q[i];
      end
    end
  end

  assign valid_o     = out_v_q;
  assign yaw_deg_o   = yaw_q;
  assign pitch_deg_o = pitch_q;

endmodule

`default_nettype wire

// ===== rtl/vtyp_checker.sv =====
// ----------------------------------------------------------------------------
// vtyp_checker
// port-level checks for the yaw/pitch pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module vtyp_checker #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       stall_o,
  input wire logic                       valid_o,
  input wire logic                       stall_i,
  input wire logic [ANGLE_FRAC_BITS+8:0] yaw_deg_o,
  input wire logic [ANGLE_FRAC_BITS+8:0] pitch_deg_o
);

  localparam logic [ANGLE_FRAC_BITS+8:0] FULL =
    (ANGLE_FRAC_BITS+9)'(64'd360 << ANGLE_FRAC_BITS);

  a_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(yaw_deg_o) && $stable(pitch_deg_o))
    else $error("stalled output beat changed");

  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("input stall does not follow output backpressure");

  a_yaw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> yaw_deg_o < FULL)
    else $error("yaw out of range");

  a_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> pitch_deg_o < FULL)
    else $error("pitch out of range");

endmodule

bind vector_to_yaw_pitch_top vtyp_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_vtyp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .stall_o     (stall_o),
  .valid_o     (valid_o),
  .stall_i     (stall_i),
  .yaw_deg_o   (yaw_deg_o),
  .pitch_deg_o (pitch_deg_o)
);

`default_nettype wire

// ===== bench/vector_to_yaw_pitch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_checker
// watches both channels, predicts yaw and pitch for each accepted vector and
// compares every output beat, in order, with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module vector_to_yaw_pitch_checker #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic                              stall_o,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_z_i,
  input  wire logic                              valid_o,
  input  wire logic                              stall_i,
  input  wire logic [ANGLE_FRAC_BITS+8:0]        yaw_deg_o,
  input  wire logic [ANGLE_FRAC_BITS+8:0]        pitch_deg_o,
  output int                                     fail_cnt_o,
  output int                                     pending_o
);

  localparam int OW = ANGLE_FRAC_BITS + 9;
  localparam int NSTEPS = 40;
  localparam int AFRAC = 32;
  localparam int NTOP = 46;
  localparam longint unsigned GAIN = 64'd1768195363;
  localparam longint RAD2DEG = 64'sd246083499208;

  typedef struct packed {
    logic [OW-1:0] yaw;
    logic [OW-1:0] pitch;
  } angles_t;

  angles_t angles_q[$];
  int fail_cnt;

  localparam longint ATAN_Q32 [14] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239180,  64'sd7687607525,   64'sd3844741810,  64'sd1922488225,
    64'sd961258780,    64'sd480631223,    64'sd240315841,   64'sd120157949,
    64'sd60078978,     64'sd30039489
  };

  function automatic longint rot_angle(int i);
    if (i < 14) return ATAN_Q32[i];
    return (RAD2DEG + (64'sd1 <<< (i - 1))) >>> i;
  endfunction

  function automatic int lead_shift(longint unsigned m);
    int s;
    s = 0;
    while (m < (64'd1 << NTOP) && s < 63) begin
      m = m << 1;
      s++;
    end
    return s;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic void rotate(inout longint x, input longint y, inout longint acc);
    longint dx, dy;
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += rot_angle(i);
      end else begin
        x -= dx; y += dy; acc -= rot_angle(i);
      end
    end
  endfunction

  function automatic logic [OW-1:0] round_deg(longint acc);
    int sh;
    longint full, r;
    sh = AFRAC - ANGLE_FRAC_BITS;
    full = 64'sd360 <<< ANGLE_FRAC_BITS;
    r = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r < 0) r += full;
    if (r >= full) r -= full;
    return r[OW-1:0];
  endfunction

  function automatic angles_t predict_angles(longint x, longint y, longint z);
    angles_t a;
    longint unsigned mx, my, mz, bz, r, hi, lo;
    int s1, s2;
    longint xs, ys, acc, rx, y2, acc2;
    if (x == 0 && y == 0) begin
      a.yaw = '0;
      a.pitch = OW'((z > 0 ? 64'sd270 : 64'sd90) <<< ANGLE_FRAC_BITS);
      return a;
    end
    mx = magnitude(x);
    my = magnitude(y);
    s1 = lead_shift(mx > my ? mx : my);
    xs = longint'(mx << s1); if (x < 0) xs = -xs;
    ys = longint'(my << s1); if (y < 0) ys = -ys;
    acc = 0;
    if (xs < 0) begin
      xs = -xs; ys = -ys; acc = 64'sd180 <<< AFRAC;
    end
    rotate(xs, ys, acc);
    a.yaw = round_deg(acc);
    r = xs;
    mz = magnitude(z);
    if (mz == 0) begin
      s2 = s1; bz = 0;
    end else begin
      s2 = lead_shift(mz);
      hi = ((mz << s2) >> 24) * GAIN;
      lo = ((mz << s2) & 64'hFFFFFF) * GAIN;
      bz = (hi >> 6) + ((((hi & 64'd63) << 24) + lo) >> 30);
    end
    if (s1 > s2) r = (s1 - s2 >= 64) ? 0 : r >> (s1 - s2);
    else if (s2 > s1) bz = (s2 - s1 >= 64) ? 0 : bz >> (s2 - s1);
    rx = r;
    y2 = (z > 0) ? -longint'(bz) : longint'(bz);
    acc2 = 0;
    rotate(rx, y2, acc2);
    a.pitch = round_deg(acc2);
    return a;
  endfunction

  assign fail_cnt_o = fail_cnt;
  assign pending_o = angles_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t want;
    if (!rst_ni) begin
      fail_cnt <= 0;
      angles_q.delete();
    end else begin
      if (valid_i && !stall_o) begin
        angles_q.push_back(predict_angles(vec_x_i, vec_y_i, vec_z_i));
      end
      if (valid_o && !stall_i) begin
        if (angles_q.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected beat yaw=%0d pitch=%0d", yaw_deg_o,
                                      pitch_deg_o);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = angles_q.pop_front();
          if (want.yaw !== yaw_deg_o || want.pitch !== pitch_deg_o) begin
            if (fail_cnt < 10) begin
              $display("mismatch yaw exp=%0d got=%0d pitch exp=%0d got=%0d",
                       want.yaw, yaw_deg_o, want.pitch, pitch_deg_o);
            end
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_vector_to_yaw_pitch_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_to_yaw_pitch_top
// drives direction vectors into the yaw/pitch pipeline with bursty input and
// random output stall, including one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vector_to_yaw_pitch_top;

  localparam int CW = 32;
  localparam int AF = 16;
  localparam int N_RANDOM = 1630;

  logic clk_i, rst_ni, valid_i, stall_o, valid_o, stall_i;
  logic signed [CW-1:0] vec_x_i, vec_y_i, vec_z_i;
  logic [AF+8:0] yaw_deg_o, pitch_deg_o;
  int fail_cnt, pending;
  bit stim_done, hold_off;

  vector_to_yaw_pitch_top #(.COMPONENT_WIDTH(CW), .ANGLE_FRAC_BITS(AF)) dut (.*);

  vector_to_yaw_pitch_checker #(.COMPONENT_WIDTH(CW), .ANGLE_FRAC_BITS(AF)) u_checker (
    .fail_cnt_o(fail_cnt), .pending_o(pending), .*
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [CW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($signed($urandom_range(0, 8)) - 4);
      4: return CW'($urandom) >>> $urandom_range(0, CW - 1);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_vec(input logic signed [CW-1:0] x, y, z);
    valid_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  initial begin
    logic signed [CW-1:0] mn, mx;
    int burst;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    valid_i = 0; vec_x_i = 0; vec_y_i = 0; vec_z_i = 0;
    stim_done = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // zero horizontal part, both halves, wrap corners, extremes
    send_vec(0, 0, 5);
    send_vec(0, 0, -5);
    send_vec(0, 0, 0);
    send_vec(0, 0, mx);
    send_vec(0, 0, mn);
    send_vec(mx, 0, 0);
    send_vec(mn, 0, 0);
    send_vec(-1, 0, 0);
    send_vec(-1, -1, 1);
    send_vec(1, -1, -1);
    send_vec(0, mx, 0);
    send_vec(0, mn, 0);
    send_vec(mn, mn, mn);
    send_vec(mx, mx, mx);
    send_vec(mn, mx, mx);
    send_vec(mx, mn, mn);
    send_vec(1, 0, mn);
    send_vec(1, 0, mx);
    send_vec(mn, -1, 1);
    send_vec(mn, 1, 0);
    send_vec(-1, 1, mn);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        send_vec(pick_comp(), pick_comp(), pick_comp());
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    valid_i <= 1'b0;
    stim_done = 1;
  end

  // output stall pattern with one long hold-off early in the run
  initial begin
    int mode;
    stall_i = 0;
    hold_off = 0;
    @(posedge rst_ni);
    repeat (60) @(posedge clk_i);
    hold_off = 1;
    stall_i <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        case (mode)
          0: stall_i <= 1'b0;
          1: stall_i <= ($urandom_range(0, 3) == 0);
          2: stall_i <= ($urandom_range(0, 1) == 0);
          default: stall_i <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/vtyp_pkg.sv
rtl/vector_to_yaw_pitch_top.sv
rtl/vtyp_checker.sv
bench/vector_to_yaw_pitch_checker.sv
bench/tb_vector_to_yaw_pitch_top.sv
